// File: hw/rtl/hrp_pkg.sv
package hrp_pkg;

    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] BYTE_MASK  = 8'hff;
    localparam logic [7:0] TYPE_EOF   = 8'h01;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_stream;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] byte_address;
        logic [7:0]  data_byte;
        logic [7:0]  record_type;
        logic [7:0]  record_length;
    } out_word_t;

    typedef enum logic [2:0] {
        KIND_DATA = 3'd0,
        KIND_OK   = 3'd1,
        KIND_CSUM = 3'd2,
        KIND_FMT  = 3'd3,
        KIND_EOF  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        TK_SPACE,
        TK_COLON,
        TK_HEX,
        TK_OTHER,
        TK_EOS
    } tok_class_t;

    typedef struct packed {
        tok_class_t cls;
        logic [3:0] digit;
    } token_t;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_LEN  = 3'd1,
        PH_ADDR = 3'd2,
        PH_TYPE = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5,
        PH_SKIP = 3'd6
    } phase_t;

endpackage

// File: hw/rtl/hrp_front.sv
module hrp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  hrp_pkg::in_word_t in_data,
    output logic              tok_valid,
    output hrp_pkg::token_t   tok,
    input  logic              tok_pop
);

    hrp_pkg::token_t tok_cls;
    hrp_pkg::token_t entry_reg [2];
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic            do_push;
    logic            do_pop;
    logic [7:0]      c;

    assign c = in_data.character;

    // character classification; hex value is only meaningful for TK_HEX
    always_comb
    begin
        tok_cls.digit = 4'd0;
        if (in_data.end_of_stream)
        begin
            tok_cls.cls = hrp_pkg::TK_EOS;
        end
        else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
        begin
            tok_cls.cls = hrp_pkg::TK_SPACE;
        end
        else if (c == hrp_pkg::COLON_CHAR)
        begin
            tok_cls.cls = hrp_pkg::TK_COLON;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            tok_cls.cls   = hrp_pkg::TK_HEX;
            tok_cls.digit = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            tok_cls.cls   = hrp_pkg::TK_HEX;
            tok_cls.digit = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        else
        begin
            tok_cls.cls = hrp_pkg::TK_OTHER;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign tok_valid = (count_reg != 2'd0);
    assign tok       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = tok_pop && tok_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= tok_cls;
        end
    end

endmodule

// File: hw/rtl/hrp_back.sv
module hrp_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tok_valid,
    input  hrp_pkg::token_t    tok,
    output logic               tok_pop,
    output logic               empty,
    input  logic               pop,
    output hrp_pkg::out_word_t out_data
);

    hrp_pkg::phase_t    phase_reg,   phase_next;
    logic [1:0]         cnt_reg,     cnt_next;
    logic [11:0]        partial_reg, partial_next;
    logic [7:0]         length_reg,  length_next;
    logic [15:0]        addr_reg,    addr_next;
    logic [7:0]         type_reg,    type_next;
    logic [7:0]         sum_reg,     sum_next;
    logic [7:0]         offset_reg,  offset_next;
    logic               halted_reg,  halted_next;

    hrp_pkg::out_word_t res;
    logic               res_valid;
    hrp_pkg::kind_t     res_kind;
    logic               take;
    logic [15:0]        value;
    logic [7:0]         byte_val;
    logic [1:0]         last_cnt;
    logic [7:0]         sum_chk;
    logic [7:0]         offset_inc;

    hrp_pkg::out_word_t entry_reg [2];
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic               res_full;
    logic               do_pop;

    assign res_full = (count_reg == 2'd2);
    assign take     = tok_valid && !res_full;
    assign tok_pop  = take;

    assign value      = {partial_reg, tok.digit};
    assign byte_val   = value[7:0];
    assign last_cnt   = (phase_reg == hrp_pkg::PH_ADDR) ? 2'd3 : 2'd1;
    assign sum_chk    = sum_reg + byte_val;
    assign offset_inc = offset_reg + 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        partial_next = partial_reg;
        length_next  = length_reg;
        addr_next    = addr_reg;
        type_next    = type_reg;
        sum_next     = sum_reg;
        offset_next  = offset_reg;
        halted_next  = halted_reg;
        res_valid    = 1'b0;
        res_kind     = hrp_pkg::KIND_FMT;

        if (take && !halted_reg)
        begin
            if (tok.cls == hrp_pkg::TK_EOS)
            begin
                halted_next = 1'b1;
                res_valid   = 1'b1;
            end
            else
            begin
                unique case (phase_reg) inside
                    hrp_pkg::PH_WAIT:
                    begin
                        if (tok.cls == hrp_pkg::TK_COLON)
                        begin
                            length_next  = 8'd0;
                            addr_next    = 16'd0;
                            type_next    = 8'd0;
                            sum_next     = 8'd0;
                            offset_next  = 8'd0;
                            cnt_next     = 2'd0;
                            partial_next = 12'd0;
                            phase_next   = hrp_pkg::PH_LEN;
                        end
                        else if (tok.cls != hrp_pkg::TK_SPACE)
                        begin
                            halted_next = 1'b1;
                            res_valid   = 1'b1;
                        end
                    end
                    hrp_pkg::PH_LEN, hrp_pkg::PH_ADDR, hrp_pkg::PH_TYPE,
                    hrp_pkg::PH_DATA, hrp_pkg::PH_SUM:
                    begin
                        if (tok.cls != hrp_pkg::TK_HEX)
                        begin
                            halted_next = 1'b1;
                            res_valid   = 1'b1;
                        end
                        else if (cnt_reg != last_cnt)
                        begin
                            cnt_next     = cnt_reg + 2'd1;
                            partial_next = value[11:0];
                        end
                        else
                        begin
                            cnt_next     = 2'd0;
                            partial_next = 12'd0;
                            unique case (phase_reg)
                                hrp_pkg::PH_LEN:
                                begin
                                    length_next = byte_val;
                                    sum_next    = sum_chk;
                                    phase_next  = hrp_pkg::PH_ADDR;
                                end
                                hrp_pkg::PH_ADDR:
                                begin
                                    addr_next  = value;
                                    sum_next   = sum_reg + value[15:8] + value[7:0];
                                    phase_next = hrp_pkg::PH_TYPE;
                                end
                                hrp_pkg::PH_TYPE:
                                begin
                                    type_next = byte_val;
                                    sum_next  = sum_chk;
                                    if (byte_val == hrp_pkg::TYPE_EOF)
                                    begin
                                        halted_next = 1'b1;
                                        res_valid   = 1'b1;
                                        res_kind    = hrp_pkg::KIND_EOF;
                                    end
                                    else if (length_reg == 8'd0)
                                    begin
                                        halted_next = 1'b1;
                                        res_valid   = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = hrp_pkg::PH_DATA;
                                    end
                                end
                                hrp_pkg::PH_DATA:
                                begin
                                    sum_next    = sum_chk;
                                    offset_next = offset_inc;
                                    res_valid   = 1'b1;
                                    res_kind    = hrp_pkg::KIND_DATA;
                                    if (offset_inc == length_reg)
                                    begin
                                        phase_next = hrp_pkg::PH_SUM;
                                    end
                                end
                                default:
                                begin
                                    sum_next  = sum_chk;
                                    res_valid = 1'b1;
                                    if (sum_chk != 8'd0)
                                    begin
                                        halted_next = 1'b1;
                                        res_kind    = hrp_pkg::KIND_CSUM;
                                    end
                                    else
                                    begin
                                        res_kind   = hrp_pkg::KIND_OK;
                                        phase_next = hrp_pkg::PH_SKIP;
                                    end
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        // trailing text after the checksum
                        if (tok.cls == hrp_pkg::TK_SPACE)
                        begin
                            phase_next = hrp_pkg::PH_WAIT;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res.kind          = res_kind;
        res.record_type   = type_next;
        res.record_length = length_next;
        if (res_kind == hrp_pkg::KIND_DATA)
        begin
            res.byte_address = addr_reg + {8'd0, offset_reg};
            res.data_byte    = byte_val;
        end
        else
        begin
            res.byte_address = addr_next;
            res.data_byte    = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= hrp_pkg::PH_WAIT;
            cnt_reg     <= 2'd0;
            partial_reg <= 12'd0;
            length_reg  <= 8'd0;
            addr_reg    <= 16'd0;
            type_reg    <= 8'd0;
            sum_reg     <= 8'd0;
            offset_reg  <= 8'd0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            partial_reg <= partial_next;
            length_reg  <= length_next;
            addr_reg    <= addr_next;
            type_reg    <= type_next;
            sum_reg     <= sum_next;
            offset_reg  <= offset_next;
            halted_reg  <= halted_next;
        end
    end

    // two-word result queue
    assign empty    = (count_reg == 2'd0);
    assign out_data = entry_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (res_valid && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !res_valid)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (res_valid)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            entry_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

// File: hw/rtl/hex_record_parser.sv
// Intel HEX record parser, one character word per cycle while full is low.
// Path: a taken character is classified into the token queue; the parser step
// reads it from the queue head and writes any result into the result queue,
// whose head drives out_data.
// Throughput: one character per cycle while the token and result queues have room.
// Reset (rst_n low, async): both queues empty, parser waits for a colon, not halted.
module hex_record_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  hrp_pkg::in_word_t  in_data,
    output logic               empty,
    input  logic               pop,
    output hrp_pkg::out_word_t out_data
);

    logic            tok_valid;
    logic            tok_pop;
    hrp_pkg::token_t tok;

    hrp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop)
    );

    hrp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data)
    );

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1850;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [2:0] {
        END_EOF_RECORD,
        END_STREAM_MARK,
        END_MISSING_COLON,
        END_SHORT_RECORD,
        END_BAD_DIGIT,
        END_ZERO_LENGTH,
        END_BAD_CHECKSUM
    } ending_t;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               push    = 1'b0;
    logic               full;
    hrp_pkg::in_word_t  in_data = '0;
    logic               empty;
    logic               pop     = 1'b0;
    hrp_pkg::out_word_t out_data;

    hex_record_parser dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_data  (in_data),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

    // parser state as seen by the predictor
    hrp_pkg::phase_t rx_phase  = hrp_pkg::PH_WAIT;
    logic [2:0]      nib_count = '0;
    logic [15:0]     field_acc = '0;
    logic [7:0]      hdr_len   = '0;
    logic [15:0]     hdr_addr  = '0;
    logic [7:0]      hdr_type  = '0;
    logic [7:0]      sum_acc   = '0;
    logic [7:0]      data_idx  = '0;
    logic            stopped   = 1'b0;

    hrp_pkg::out_word_t expected_reports[$];
    logic [7:0]         payload[$];
    logic [7:0]         line_chars[$];
    int                 sent_count  = 0;
    int                 error_count = 0;
    logic               calm        = 1'b0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    // letters of either case map to 10..15 through the low nibble
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c <= 8'h39)
        begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

    function automatic void emit_report(input hrp_pkg::kind_t k,
                                        input logic [15:0] addr,
                                        input logic [7:0] value);
        hrp_pkg::out_word_t o;
        o.kind          = k;
        o.byte_address  = addr;
        o.data_byte     = value;
        o.record_type   = hdr_type;
        o.record_length = hdr_len;
        expected_reports.insert(expected_reports.size(), o);
    endfunction

    function automatic void halt_report(input hrp_pkg::kind_t k);
        stopped = 1'b1;
        emit_report(k, hdr_addr, 8'h00);
    endfunction

    function automatic void predict_parse(input hrp_pkg::in_word_t w);
        logic [7:0]  c;
        logic [15:0] value;
        if (stopped)
        begin
            return;
        end
        if (w.end_of_stream)
        begin
            halt_report(hrp_pkg::KIND_FMT);
            return;
        end
        c = w.character;
        if (rx_phase == hrp_pkg::PH_WAIT)
        begin
            if (is_space(c))
            begin
                return;
            end
            if (c != hrp_pkg::COLON_CHAR)
            begin
                halt_report(hrp_pkg::KIND_FMT);
                return;
            end
            hdr_len   = '0;
            hdr_addr  = '0;
            hdr_type  = '0;
            sum_acc   = '0;
            data_idx  = '0;
            nib_count = '0;
            field_acc = '0;
            rx_phase  = hrp_pkg::PH_LEN;
            return;
        end
        if (rx_phase == hrp_pkg::PH_SKIP)
        begin
            if (is_space(c))
            begin
                rx_phase = hrp_pkg::PH_WAIT;
            end
            return;
        end
        if (is_space(c) || !is_hex(c))
        begin
            halt_report(hrp_pkg::KIND_FMT);
            return;
        end
        field_acc = {field_acc[11:0], hex_nibble(c)};
        nib_count = nib_count + 3'd1;
        if (nib_count < ((rx_phase == hrp_pkg::PH_ADDR) ? 3'd4 : 3'd2))
        begin
            return;
        end
        value     = field_acc;
        nib_count = '0;
        field_acc = '0;
        case (rx_phase)
            hrp_pkg::PH_LEN:
            begin
                hdr_len  = value[7:0];
                sum_acc  = sum_acc + value[7:0];
                rx_phase = hrp_pkg::PH_ADDR;
            end
            hrp_pkg::PH_ADDR:
            begin
                hdr_addr = value;
                sum_acc  = sum_acc + value[15:8] + value[7:0];
                rx_phase = hrp_pkg::PH_TYPE;
            end
            hrp_pkg::PH_TYPE:
            begin
                hdr_type = value[7:0];
                sum_acc  = sum_acc + value[7:0];
                if (hdr_type == hrp_pkg::TYPE_EOF)
                begin
                    halt_report(hrp_pkg::KIND_EOF);
                end
                else if (hdr_len == 8'h00)
                begin
                    halt_report(hrp_pkg::KIND_FMT);
                end
                else
                begin
                    rx_phase = hrp_pkg::PH_DATA;
                end
            end
            hrp_pkg::PH_DATA:
            begin
                sum_acc = sum_acc + value[7:0];
                emit_report(hrp_pkg::KIND_DATA, hdr_addr + 16'(data_idx), value[7:0]);
                data_idx = data_idx + 8'd1;
                if (data_idx == hdr_len)
                begin
                    rx_phase = hrp_pkg::PH_SUM;
                end
            end
            default:
            begin
                sum_acc = sum_acc + value[7:0];
                if (sum_acc != 8'h00)
                begin
                    halt_report(hrp_pkg::KIND_CSUM);
                end
                else
                begin
                    rx_phase = hrp_pkg::PH_SKIP;
                    emit_report(hrp_pkg::KIND_OK, hdr_addr, 8'h00);
                end
            end
        endcase
    endfunction

    function automatic void check_report(input hrp_pkg::out_word_t got);
        hrp_pkg::out_word_t want;
        if (expected_reports.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
            begin
                $display("unexpected word: kind %0d addr %h data %h type %h len %h",
                         got.kind, got.byte_address, got.data_byte, got.record_type,
                         got.record_length);
            end
            return;
        end
        want = expected_reports.pop_front();
        if (got.kind !== want.kind || got.byte_address !== want.byte_address ||
            got.data_byte !== want.data_byte || got.record_type !== want.record_type ||
            got.record_length !== want.record_length)
        begin
            error_count++;
            if (error_count <= 10)
            begin
                $display("mismatch: expected kind %0d addr %h data %h type %h len %h",
                         want.kind, want.byte_address, want.data_byte, want.record_type,
                         want.record_length);
                $display("          got      kind %0d addr %h data %h type %h len %h",
                         got.kind, got.byte_address, got.data_byte, got.record_type,
                         got.record_length);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            check_report(out_data);
        end
        pop <= calm || ($urandom_range(99) >= 8);
    end

    // counts cycles in which no word moves on either side
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT)
            begin
                $display("** hex_record_parser: FAILED **");
                $finish;
            end
        end
    end

    // push stays high from one word to the next unless the sender idles
    task automatic send_word(input hrp_pkg::in_word_t w);
        while (!calm && $urandom_range(99) < 8)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (full);
        predict_parse(w);
        sent_count++;
    endtask

    task automatic send_char(input logic [7:0] c);
        hrp_pkg::in_word_t w;
        w.character     = c;
        w.end_of_stream = 1'b0;
        send_word(w);
    endtask

    task automatic send_line();
        foreach (line_chars[i])
        begin
            send_char(line_chars[i]);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return 8'h30 + {4'd0, n};
        end
        return ($urandom_range(1) ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
    endfunction

    function automatic void add_hex_byte(input logic [7:0] b);
        line_chars.insert(line_chars.size(), hex_char(b[7:4]));
        line_chars.insert(line_chars.size(), hex_char(b[3:0]));
    endfunction

    // record text from payload; csum_skew != 0 spoils the checksum
    function automatic void build_record(input logic [15:0] addr, input logic [7:0] rtype,
                                         input logic [7:0] csum_skew);
        logic [7:0] csum;
        csum = 8'(payload.size()) + addr[15:8] + addr[7:0] + rtype;
        line_chars.delete();
        line_chars.insert(0, hrp_pkg::COLON_CHAR);
        add_hex_byte(8'(payload.size()));
        add_hex_byte(addr[15:8]);
        add_hex_byte(addr[7:0]);
        add_hex_byte(rtype);
        foreach (payload[i])
        begin
            add_hex_byte(payload[i]);
            csum = csum + payload[i];
        end
        add_hex_byte(8'h00 - csum + csum_skew);
    endfunction

    function automatic void fill_payload(input int count);
        payload.delete();
        repeat (count)
        begin
            payload.insert(payload.size(), 8'($urandom_range(255)));
        end
    endfunction

    function automatic logic [7:0] rand_junk();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (is_space(c));
        return c;
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(5))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0A;
            3:       return 8'h0B;
            4:       return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic logic [15:0] rand_addr();
        if ($urandom_range(7) == 0)
        begin
            return 16'hFFF0 + 16'($urandom_range(15));
        end
        return 16'($urandom_range(16'hFFFF));
    endfunction

    function automatic logic [7:0] rand_data_type();
        logic [7:0] t;
        if ($urandom_range(1) == 0)
        begin
            return 8'h00;
        end
        do
            t = 8'($urandom_range(255));
        while (t == hrp_pkg::TYPE_EOF);
        return t;
    endfunction

    // optional junk after the checksum, then the separator
    task automatic send_tail();
        if ($urandom_range(3) == 0)
        begin
            repeat ($urandom_range(1, 3)) send_char(rand_junk());
        end
        repeat ($urandom_range(1, 3)) send_char(rand_space());
    endtask

    task automatic send_record(input int count, input logic [15:0] addr,
                               input logic [7:0] rtype);
        fill_payload(count);
        build_record(addr, rtype, 8'h00);
        send_line();
        send_tail();
    endtask

    task automatic test_directed_record();
        send_char(8'h20);
        send_char(8'h09);
        send_char(8'h0A);
        send_char(8'h0B);
        send_char(8'h0C);
        send_char(8'h0D);
        // top address so the second data byte wraps to 0000
        payload = {8'hFF, 8'h00};
        build_record(16'hFFFF, 8'hFF, 8'h00);
        send_line();
        send_char(8'h80);
        send_char(8'h20);
    endtask

    task automatic test_drain_pause();
        push <= 1'b0;
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_random_records(input int stop_at, input logic with_long);
        int n;
        n = 0;
        while (sent_count < stop_at)
        begin
            calm = with_long && n >= 15 && n < 25;
            if (with_long && n == 8)
            begin
                send_record(255, rand_addr(), rand_data_type());
            end
            else
            begin
                send_record($urandom_range(1, 16), rand_addr(), rand_data_type());
            end
            n++;
        end
        calm = 1'b0;
    endtask

    // the parser halts for good here, so one ending is picked per run
    task automatic test_terminal_case();
        ending_t           how;
        int                cut;
        logic [7:0]        c;
        hrp_pkg::in_word_t w;
        how = ending_t'($urandom_range(6));
        case (how)
            END_EOF_RECORD:
            begin
                fill_payload($urandom_range(0, 4));
                build_record(rand_addr(), hrp_pkg::TYPE_EOF, 8'h00);
                send_line();
                send_tail();
            end
            END_STREAM_MARK:
            begin
                fill_payload($urandom_range(1, 4));
                build_record(rand_addr(), rand_data_type(), 8'h00);
                cut = $urandom_range(0, line_chars.size());
                for (int i = 0; i < cut; i++)
                begin
                    send_char(line_chars[i]);
                end
                w.character     = 8'($urandom_range(255));
                w.end_of_stream = 1'b1;
                send_word(w);
            end
            END_MISSING_COLON:
            begin
                do
                    c = rand_junk();
                while (c == hrp_pkg::COLON_CHAR);
                send_char(c);
            end
            END_SHORT_RECORD:
            begin
                fill_payload($urandom_range(1, 8));
                build_record(rand_addr(), rand_data_type(), 8'h00);
                cut = $urandom_range(1, line_chars.size() - 1);
                line_chars[cut] = rand_space();
                send_line();
                send_tail();
            end
            END_BAD_DIGIT:
            begin
                fill_payload($urandom_range(1, 8));
                build_record(rand_addr(), rand_data_type(), 8'h00);
                cut = $urandom_range(1, line_chars.size() - 1);
                do
                    c = rand_junk();
                while (is_hex(c));
                line_chars[cut] = c;
                send_line();
                send_tail();
            end
            END_ZERO_LENGTH:
            begin
                payload.delete();
                build_record(rand_addr(), rand_data_type(), 8'h00);
                send_line();
                send_tail();
            end
            default:
            begin
                fill_payload($urandom_range(1, 8));
                build_record(rand_addr(), rand_data_type(), 8'($urandom_range(1, 255)));
                send_line();
                send_tail();
            end
        endcase
    endtask

    // once halted, every word must be swallowed silently
    task automatic test_after_halt();
        hrp_pkg::in_word_t w;
        for (int i = 0; i < 40; i++)
        begin
            w.character     = 8'($urandom_range(255));
            w.end_of_stream = (i == 0) ? 1'b1 : 1'($urandom_range(1));
            send_word(w);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_record();
        test_drain_pause();
        test_random_records(ITEM_TARGET / 2, 1'b1);
        test_drain_pause();
        test_random_records(ITEM_TARGET - 80, 1'b0);
        test_terminal_case();
        test_after_halt();
        test_drain_pause();
        if (error_count == 0 && expected_reports.size() == 0)
        begin
            $display("** hex_record_parser: PASSED **");
        end
        else
        begin
            $display("** hex_record_parser: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/hrp_pkg.sv
hw/rtl/hrp_front.sv
hw/rtl/hrp_back.sv
hw/rtl/hex_record_parser.sv
tb/tb.sv
